### rtl/cpts_pkg.sv
// ---------------------------------------------------------------------------
// cpts_pkg: shared types and constants of the counter-priority scheduler
// Slot table geometry, event codes, sequencer states and the records that
// pass between the sequencer, the slot table and the arithmetic unit.
// ---------------------------------------------------------------------------
package cpts_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int IDX_W      = $clog2(TASK_SLOTS + 1);
    localparam int CNT_W      = 9;
    localparam int PRIO_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int OUT_SLOT_W = 6;

    // Event codes carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_YIELD  = 2'd1,
        FUNC_EXIT   = 2'd2,
        FUNC_CREATE = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_REFILL,
        ST_DONE
    } state_t;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_DEC,
        ALU_REFILL
    } alu_op_t;

    // Requests from the sequencer to the slot table
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              cnt_we;
        logic [SLOT_W-1:0] wr_addr;
        logic [CNT_W-1:0]  cnt_wdata;
        logic              create;
        logic [PRIO_W-1:0] prio_wdata;
        logic              zombie_set;
    } tbl_cmd_t;

    // Slot table read data, for the address issued in the previous cycle
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [PRIO_W-1:0] prio;
        logic              present;
        logic              runnable;
    } tbl_rsp_t;

    // One result item
    typedef struct packed {
        logic                  stuck;
        logic                  recomputed;
        logic                  switched;
        logic [OUT_SLOT_W-1:0] current_slot;
    } result_t;

endpackage

### rtl/counter_priority_task_scheduler.sv
// ---------------------------------------------------------------------------
// counter_priority_task_scheduler: counter-priority task scheduler
// Slot table of tasks with present, zombie, priority and time-slice counter;
// each event yields the running slot after it.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one event per item. s_tuser carries the event kind
//   (tick, yield, exit current, create), s_tdata the create arguments.
//   Output stream m_*: exactly one result item per event, in order.
//   cfg_we/cfg_wdata write the idle task priority; write it only while idle.
// Steps per event (accepted event to result valid):
//   Create: straight to the result state. Tick without reschedule: a
//   counter read state, then the result state. Yield or exit: a scan of
//   every slot, then the result state. A refill adds a refill pass and a
//   rescan, and a tick that reschedules adds its counter read state first.
//   The work is set by the single read port of the counter memory, which
//   the scan and the refill walk one slot per cycle.
//   s_tready is high only while the sequencer waits for an event.
// Reset:
//   Only the idle slot 0 is present, all counters read zero, slot 0 runs,
//   and the idle priority is 1. No clearing pass is needed.
// Stall:
//   A result waits in the output register; the next event is still taken,
//   and its result is held in the sequencer until the register frees.
// ---------------------------------------------------------------------------
module counter_priority_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [5:0] slot, [13:6] priority_req, [22:14] start_count
    input  logic [1:0]  s_tuser,    // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [5:0] current_slot, [6] switched, [7] recomputed,
                                    // [8] stuck
);

    logic [cpts_pkg::PRIO_W-1:0] idle_priority_reg;
    logic                        m_tvalid_reg;
    cpts_pkg::result_t           out_reg;

    cpts_pkg::tbl_cmd_t          cmd;
    cpts_pkg::tbl_rsp_t          rsp;
    cpts_pkg::result_t           res;
    logic                        res_load;
    logic                        res_ok;

    // Hold the idle priority
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_priority_reg <= cpts_pkg::PRIO_W'(1);
        end
        else if (cfg_we)
        begin
            idle_priority_reg <= cfg_wdata;
        end
    end

    cpts_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (cpts_pkg::func_t'(s_tuser)),
        .slot         (s_tdata[5:0]),
        .priority_req (s_tdata[13:6]),
        .start_count  (s_tdata[22:14]),
        .res_ok       (res_ok),
        .res_load     (res_load),
        .res          (res),
        .cmd          (cmd),
        .rsp          (rsp)
    );

    cpts_table u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .idle_priority (idle_priority_reg),
        .cmd           (cmd),
        .rsp           (rsp)
    );

    // Output register: free when empty or being taken this cycle
    assign res_ok = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ok)
        begin
            m_tvalid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 16'(out_reg);

endmodule

### rtl/cpts_alu.sv
// ---------------------------------------------------------------------------
// cpts_alu: shared arithmetic unit of the scheduler
// One 9-bit adder/comparator used for counter compare during scans,
// tick decrement and the half-plus-priority refill.
// ---------------------------------------------------------------------------
module cpts_alu (
    input  cpts_pkg::alu_op_t            op,
    input  logic [cpts_pkg::CNT_W-1:0]   a,
    input  logic [cpts_pkg::CNT_W-1:0]   b,
    output logic [cpts_pkg::CNT_W-1:0]   result,
    output logic                         gt
);

    // Compare is always available alongside the selected result
    assign gt = (a > b);

    // Select the arithmetic result
    always_comb
    begin
        case (op)
            cpts_pkg::ALU_DEC:    result = a - cpts_pkg::CNT_W'(1);
            cpts_pkg::ALU_REFILL: result = (a >> 1) + b;
            default:              result = a;
        endcase
    end

endmodule

### rtl/cpts_table.sv
// ---------------------------------------------------------------------------
// cpts_table: task slot table
// Counter and priority memories with one registered read port and one
// write port, plus present, zombie and counter-valid flags in flops.
// ---------------------------------------------------------------------------
module cpts_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cpts_pkg::PRIO_W-1:0]   idle_priority,
    input  cpts_pkg::tbl_cmd_t            cmd,
    output cpts_pkg::tbl_rsp_t            rsp
);

    logic [cpts_pkg::CNT_W-1:0]  cnt_mem  [cpts_pkg::TASK_SLOTS];
    logic [cpts_pkg::PRIO_W-1:0] prio_mem [cpts_pkg::TASK_SLOTS];

    logic [cpts_pkg::TASK_SLOTS-1:0] present_reg;
    logic [cpts_pkg::TASK_SLOTS-1:0] zombie_reg;
    logic [cpts_pkg::TASK_SLOTS-1:0] cval_reg;

    logic [cpts_pkg::CNT_W-1:0]  cnt_q_reg;
    logic [cpts_pkg::PRIO_W-1:0] prio_q_reg;
    logic                        cval_q_reg;
    logic                        present_q_reg;
    logic                        zombie_q_reg;
    logic                        is_idle_q_reg;

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_we)
        begin
            cnt_mem[cmd.wr_addr] <= cmd.cnt_wdata;
        end
        if (cmd.create)
        begin
            prio_mem[cmd.wr_addr] <= cmd.prio_wdata;
        end
        cnt_q_reg  <= cnt_mem[cmd.rd_addr];
        prio_q_reg <= prio_mem[cmd.rd_addr];
    end

    // Update slot flags; only the idle slot is present after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= cpts_pkg::TASK_SLOTS'(1);
            zombie_reg  <= '0;
            cval_reg    <= '0;
        end
        else
        begin
            if (cmd.cnt_we)
            begin
                cval_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.create)
            begin
                present_reg[cmd.wr_addr] <= 1'b1;
                zombie_reg[cmd.wr_addr]  <= 1'b0;
            end
            else if (cmd.zombie_set)
            begin
                zombie_reg[cmd.wr_addr] <= 1'b1;
            end
        end
    end

    // Register flags of the read address alongside the memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cval_q_reg    <= 1'b0;
            present_q_reg <= 1'b0;
            zombie_q_reg  <= 1'b0;
            is_idle_q_reg <= 1'b0;
        end
        else
        begin
            cval_q_reg    <= cval_reg[cmd.rd_addr];
            present_q_reg <= present_reg[cmd.rd_addr];
            zombie_q_reg  <= zombie_reg[cmd.rd_addr];
            is_idle_q_reg <= (cmd.rd_addr == '0);
        end
    end

    // Never-written counters read as zero; the idle slot takes its priority from config
    always_comb
    begin
        rsp.cnt      = cval_q_reg ? cnt_q_reg : '0;
        rsp.prio     = is_idle_q_reg ? idle_priority : prio_q_reg;
        rsp.present  = present_q_reg;
        rsp.runnable = present_q_reg & ~zombie_q_reg;
    end

endmodule

### rtl/cpts_seq.sv
// ---------------------------------------------------------------------------
// cpts_seq: event sequencer of the scheduler
// Takes one event at a time, walks the slot table one slot per cycle for
// the best-counter scan and the refill pass, and drives the shared unit.
// ---------------------------------------------------------------------------
module cpts_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpts_pkg::func_t               func,
    input  logic [cpts_pkg::SLOT_W-1:0]   slot,
    input  logic [cpts_pkg::PRIO_W-1:0]   priority_req,
    input  logic [cpts_pkg::CNT_W-1:0]    start_count,
    input  logic                          res_ok,
    output logic                          res_load,
    output cpts_pkg::result_t             res,
    output cpts_pkg::tbl_cmd_t            cmd,
    input  cpts_pkg::tbl_rsp_t            rsp
);

    localparam logic [cpts_pkg::IDX_W-1:0] IDX_END = cpts_pkg::IDX_W'(cpts_pkg::TASK_SLOTS);

    cpts_pkg::state_t state_reg, state_next;
    logic [cpts_pkg::SLOT_W-1:0] cur_reg, cur_next;
    logic [cpts_pkg::SLOT_W-1:0] before_reg, before_next;
    logic [cpts_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        pend_reg, pend_next;
    logic [cpts_pkg::SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic                        found_reg, found_next;
    logic [cpts_pkg::SLOT_W-1:0] best_reg, best_next;
    logic [cpts_pkg::CNT_W-1:0]  bestc_reg, bestc_next;
    logic                        recomp_reg, recomp_next;
    logic                        stuck_reg, stuck_next;

    cpts_pkg::alu_op_t           alu_op;
    logic [cpts_pkg::CNT_W-1:0]  alu_b;
    logic [cpts_pkg::CNT_W-1:0]  alu_result;
    logic                        alu_gt;
    logic                        idx_more;
    logic                        pass_end;

    cpts_alu u_alu (
        .op     (alu_op),
        .a      (rsp.cnt),
        .b      (alu_b),
        .result (alu_result),
        .gt     (alu_gt)
    );

    assign idx_more = (idx_reg < IDX_END);
    assign pass_end = !idx_more && !pend_reg;

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cpts_pkg::ST_IDLE;
            cur_reg      <= '0;
            before_reg   <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            bestc_reg    <= '0;
            recomp_reg   <= 1'b0;
            stuck_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            before_reg   <= before_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            found_reg    <= found_next;
            best_reg     <= best_next;
            bestc_reg    <= bestc_next;
            recomp_reg   <= recomp_next;
            stuck_reg    <= stuck_next;
        end
    end

    // Next state, table commands and shared-unit control
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        before_next   = before_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        bestc_next    = bestc_reg;
        recomp_next   = recomp_reg;
        stuck_next    = stuck_reg;

        in_ready = 1'b0;
        res_load = 1'b0;
        alu_op   = cpts_pkg::ALU_CMP;
        alu_b    = bestc_reg;

        cmd            = '0;
        cmd.rd_addr    = idx_reg[cpts_pkg::SLOT_W-1:0];
        cmd.wr_addr    = cur_reg;
        cmd.prio_wdata = priority_req;

        case (state_reg)
            cpts_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    before_next = cur_reg;
                    recomp_next = 1'b0;
                    stuck_next  = 1'b0;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    bestc_next  = '0;
                    case (func)
                        cpts_pkg::FUNC_TICK:
                        begin
                            cmd.rd_addr = cur_reg;
                            state_next  = cpts_pkg::ST_TICK;
                        end
                        cpts_pkg::FUNC_YIELD:
                        begin
                            cmd.cnt_we = 1'b1;
                            state_next = cpts_pkg::ST_SCAN;
                        end
                        cpts_pkg::FUNC_EXIT:
                        begin
                            cmd.cnt_we     = 1'b1;
                            cmd.zombie_set = 1'b1;
                            state_next     = cpts_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // Create: the idle slot is refused
                            if (slot != '0)
                            begin
                                cmd.cnt_we    = 1'b1;
                                cmd.create    = 1'b1;
                                cmd.wr_addr   = slot;
                                cmd.cnt_wdata = start_count;
                            end
                            state_next = cpts_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            cpts_pkg::ST_TICK:
            begin
                // Decrement above one, otherwise drop to zero and reschedule
                alu_op = cpts_pkg::ALU_DEC;
                alu_b  = cpts_pkg::CNT_W'(1);
                cmd.cnt_we = 1'b1;
                if (alu_gt)
                begin
                    cmd.cnt_wdata = alu_result;
                    state_next    = cpts_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cpts_pkg::ST_SCAN;
                end
            end

            cpts_pkg::ST_SCAN:
            begin
                // Issue the next slot read
                pend_next = idx_more;
                if (idx_more)
                begin
                    pend_idx_next = idx_reg[cpts_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + cpts_pkg::IDX_W'(1);
                end
                // Keep the runnable slot with the highest counter, first one on ties
                if (pend_reg && rsp.runnable && (!found_reg || alu_gt))
                begin
                    found_next = 1'b1;
                    best_next  = pend_idx_reg;
                    bestc_next = rsp.cnt;
                end
                if (pass_end)
                begin
                    if (found_reg && (bestc_reg == '0) && !recomp_reg)
                    begin
                        idx_next   = '0;
                        state_next = cpts_pkg::ST_REFILL;
                    end
                    else
                    begin
                        if (!found_reg || (bestc_reg == '0))
                        begin
                            cur_next   = '0;
                            stuck_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = best_reg;
                        end
                        state_next = cpts_pkg::ST_DONE;
                    end
                end
            end

            cpts_pkg::ST_REFILL:
            begin
                pend_next = idx_more;
                if (idx_more)
                begin
                    pend_idx_next = idx_reg[cpts_pkg::SLOT_W-1:0];
                    idx_next      = idx_reg + cpts_pkg::IDX_W'(1);
                end
                // Refill each present slot to half its counter plus priority
                alu_op = cpts_pkg::ALU_REFILL;
                alu_b  = cpts_pkg::CNT_W'(rsp.prio);
                if (pend_reg && rsp.present)
                begin
                    cmd.cnt_we    = 1'b1;
                    cmd.wr_addr   = pend_idx_reg;
                    cmd.cnt_wdata = alu_result;
                end
                if (pass_end)
                begin
                    recomp_next = 1'b1;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    bestc_next  = '0;
                    state_next  = cpts_pkg::ST_SCAN;
                end
            end

            cpts_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it has room
                if (res_ok)
                begin
                    res_load   = 1'b1;
                    state_next = cpts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpts_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.current_slot = cpts_pkg::OUT_SLOT_W'(cur_reg);
    assign res.switched     = (cur_reg != before_reg);
    assign res.recomputed   = recomp_reg;
    assign res.stuck        = stuck_reg;

endmodule

### verif/cpts_pick_monitor.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cpts_pick_monitor: prediction and comparison of scheduler picks
// Watches the event, result and register channels of the scheduler. Every
// accepted event runs through a private copy of the slot table, and the
// predicted pick is queued. Every accepted result is compared field by field
// with the oldest queued pick. Hands the mismatch count, the number of picks
// still awaited and the predicted running slot to the testbench top.
// ---------------------------------------------------------------------------
module cpts_pick_monitor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [7:0]                  cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [23:0]                 s_tdata,    // [5:0] slot, [13:6] priority_req,
                                                    // [22:14] start_count
    input  logic [1:0]                  s_tuser,    // [1:0] func
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,    // [5:0] current_slot, [6] switched,
                                                    // [7] recomputed, [8] stuck
    output int                          mismatch_count,
    output int                          picks_pending,
    output logic [cpts_pkg::SLOT_W-1:0] pred_current
);

    localparam int REPORT_LIMIT = 10;

    // Private copy of the slot table
    logic                        present_q [cpts_pkg::TASK_SLOTS];
    logic                        zombie_q  [cpts_pkg::TASK_SLOTS];
    logic [cpts_pkg::PRIO_W-1:0] prio_q    [cpts_pkg::TASK_SLOTS];
    logic [cpts_pkg::CNT_W-1:0]  count_q   [cpts_pkg::TASK_SLOTS];
    logic [cpts_pkg::SLOT_W-1:0] run_slot;
    logic [cpts_pkg::PRIO_W-1:0] idle_prio;

    cpts_pkg::result_t pick_queue [$];
    int                errs;

    // Slot 0 always takes its priority from the register
    function automatic logic [cpts_pkg::PRIO_W-1:0] slot_prio(int idx);
        return (idx == 0) ? idle_prio : prio_q[idx];
    endfunction

    // Find the runnable slot with the highest counter, lowest index on a tie
    function automatic logic find_runnable(output logic [cpts_pkg::SLOT_W-1:0] best,
                                           output logic [cpts_pkg::CNT_W-1:0] best_cnt);
        logic found;
        int   i;
        found    = 1'b0;
        best     = '0;
        best_cnt = '0;
        for (i = 0; i < cpts_pkg::TASK_SLOTS; i++)
        begin
            if (present_q[i] && !zombie_q[i] && (!found || count_q[i] > best_cnt))
            begin
                found    = 1'b1;
                best     = cpts_pkg::SLOT_W'(i);
                best_cnt = count_q[i];
            end
        end
        return found;
    endfunction

    // Pick the next slot, refilling the counters once if all are spent
    function automatic void reschedule(output logic refilled, output logic no_pick);
        logic                        found;
        logic [cpts_pkg::SLOT_W-1:0] best;
        logic [cpts_pkg::CNT_W-1:0]  best_cnt;
        int                          i;
        refilled = 1'b0;
        no_pick  = 1'b0;
        found    = find_runnable(best, best_cnt);
        if (found && best_cnt == '0)
        begin
            // zombies are refilled too, they only never win
            for (i = 0; i < cpts_pkg::TASK_SLOTS; i++)
            begin
                if (present_q[i])
                    count_q[i] = (count_q[i] >> 1) + slot_prio(i);
            end
            refilled = 1'b1;
            found    = find_runnable(best, best_cnt);
        end
        if (!found || best_cnt == '0)
        begin
            best    = '0;
            no_pick = 1'b1;
        end
        run_slot = best;
    endfunction

    // Apply one event to the table and return the pick it leads to
    function automatic cpts_pkg::result_t predict_pick(cpts_pkg::func_t fn,
                                                       logic [cpts_pkg::SLOT_W-1:0] slot,
                                                       logic [cpts_pkg::PRIO_W-1:0] prio,
                                                       logic [cpts_pkg::CNT_W-1:0] cnt);
        cpts_pkg::result_t           res;
        logic [cpts_pkg::SLOT_W-1:0] was;
        logic                        refilled;
        logic                        no_pick;
        was      = run_slot;
        refilled = 1'b0;
        no_pick  = 1'b0;
        case (fn)
            cpts_pkg::FUNC_TICK:
            begin
                if (count_q[run_slot] > cpts_pkg::CNT_W'(1))
                    count_q[run_slot] = count_q[run_slot] - cpts_pkg::CNT_W'(1);
                else
                begin
                    count_q[run_slot] = '0;
                    reschedule(refilled, no_pick);
                end
            end
            cpts_pkg::FUNC_YIELD:
            begin
                count_q[run_slot] = '0;
                reschedule(refilled, no_pick);
            end
            cpts_pkg::FUNC_EXIT:
            begin
                zombie_q[run_slot] = 1'b1;
                count_q[run_slot]  = '0;
                reschedule(refilled, no_pick);
            end
            default:
            begin
                // the idle slot cannot be replaced
                if (slot != '0)
                begin
                    present_q[slot] = 1'b1;
                    zombie_q[slot]  = 1'b0;
                    prio_q[slot]    = prio;
                    count_q[slot]   = cnt;
                end
            end
        endcase
        res.current_slot = cpts_pkg::OUT_SLOT_W'(run_slot);
        res.switched     = (run_slot != was);
        res.recomputed   = refilled;
        res.stuck        = no_pick;
        return res;
    endfunction

    // Track events, predict picks and compare results
    always @(posedge clk or negedge rst_n)
    begin
        cpts_pkg::result_t got;
        cpts_pkg::result_t want;
        int                i;
        if (!rst_n)
        begin
            for (i = 0; i < cpts_pkg::TASK_SLOTS; i++)
            begin
                present_q[i] = (i == 0);
                zombie_q[i]  = 1'b0;
                prio_q[i]    = '0;
                count_q[i]   = '0;
            end
            run_slot  = '0;
            idle_prio = 8'd1;
            errs      = 0;
            pick_queue.delete();
            mismatch_count <= 0;
            picks_pending  <= 0;
            pred_current   <= '0;
        end
        else
        begin
            if (cfg_we)
                idle_prio = cfg_wdata;

            if (s_tvalid && s_tready)
                pick_queue.push_back(predict_pick(cpts_pkg::func_t'(s_tuser), s_tdata[5:0],
                                                  s_tdata[13:6], s_tdata[22:14]));

            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(cpts_pkg::result_t)-1:0];
                if (pick_queue.size() == 0)
                begin
                    if (errs < REPORT_LIMIT)
                        $display("unexpected result: slot %0d sw %0b rc %0b st %0b",
                                 got.current_slot, got.switched, got.recomputed, got.stuck);
                    errs++;
                end
                else
                begin
                    want = pick_queue.pop_front();
                    if (got.current_slot != want.current_slot || got.switched != want.switched
                        || got.recomputed != want.recomputed || got.stuck != want.stuck)
                    begin
                        if (errs < REPORT_LIMIT)
                            $display({"pick mismatch: expected slot %0d sw %0b rc %0b st %0b,",
                                      " got slot %0d sw %0b rc %0b st %0b"},
                                     want.current_slot, want.switched, want.recomputed,
                                     want.stuck, got.current_slot, got.switched,
                                     got.recomputed, got.stuck);
                        errs++;
                    end
                end
            end

            mismatch_count <= errs;
            picks_pending  <= pick_queue.size();
            pred_current   <= run_slot;
        end
    end

endmodule

### verif/tb_counter_priority_task_scheduler.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_counter_priority_task_scheduler: stimulus and verdict for the scheduler
// Drives a directed run over the register extremes, refused and overwriting
// creates, tie breaks, refills and stuck picks, then three random phases of
// mostly task creation and tick traffic with changing idle patterns on both
// streams, one long result stall and a final phase with the idle task gone.
// Checking is done by the pick monitor instantiated beside the block.
// ---------------------------------------------------------------------------
module tb_counter_priority_task_scheduler;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int RUN_LIMIT     = 1_000_000;
    localparam int PHASE_ITEMS   = 350;
    localparam int SETTLE_CYCLES = 140;
    localparam int STALL_CYCLES  = 400;

    typedef struct {
        cpts_pkg::func_t             fn;
        logic [cpts_pkg::SLOT_W-1:0] slot;
        logic [cpts_pkg::PRIO_W-1:0] prio;
        logic [cpts_pkg::CNT_W-1:0]  count;
    } sched_event_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    int                          mismatch_count;
    int                          picks_pending;
    logic [cpts_pkg::SLOT_W-1:0] pred_current;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic guard_idle  = 1'b1;
    logic stall_req   = 1'b0;
    logic stall_done  = 1'b0;
    int   stall_left  = 0;
    int   cycle_count = 0;

    counter_priority_task_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cpts_pick_monitor u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .picks_pending  (picks_pending),
        .pred_current   (pred_current)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result receiver: random back-pressure, one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_req && !stall_done)
        begin
            m_tready   <= 1'b0;
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic sched_event_t mk_event(cpts_pkg::func_t fn, int slot, int prio,
                                              int count);
        sched_event_t ev;
        ev.fn    = fn;
        ev.slot  = cpts_pkg::SLOT_W'(slot);
        ev.prio  = cpts_pkg::PRIO_W'(prio);
        ev.count = cpts_pkg::CNT_W'(count);
        return ev;
    endfunction

    // Mostly ticks and creates of a few reused slots with short slices
    function automatic sched_event_t random_event();
        sched_event_t ev;
        int           pick;
        pick  = $urandom_range(0, 99);
        ev.fn = (pick < 35) ? cpts_pkg::FUNC_TICK : (pick < 50) ? cpts_pkg::FUNC_YIELD :
                (pick < 62) ? cpts_pkg::FUNC_EXIT : cpts_pkg::FUNC_CREATE;
        pick    = $urandom_range(0, 99);
        ev.slot = (pick < 10) ? '0 : (pick < 70) ? cpts_pkg::SLOT_W'($urandom_range(1, 7)) :
                  cpts_pkg::SLOT_W'($urandom_range(0, cpts_pkg::TASK_SLOTS - 1));
        pick    = $urandom_range(0, 99);
        ev.prio = (pick < 15) ? '0 : (pick < 25) ? '1 : (pick < 75) ?
                  cpts_pkg::PRIO_W'($urandom_range(1, 7)) :
                  cpts_pkg::PRIO_W'($urandom_range(0, 255));
        pick     = $urandom_range(0, 99);
        ev.count = (pick < 15) ? '0 : (pick < 30) ? cpts_pkg::CNT_W'(1) : (pick < 75) ?
                   cpts_pkg::CNT_W'($urandom_range(2, 10)) :
                   cpts_pkg::CNT_W'($urandom_range(0, 511));
        return ev;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_event(sched_event_t ev);
        // keep the idle task alive until the last phase
        if (ev.fn == cpts_pkg::FUNC_EXIT && guard_idle && pred_current == '0)
            ev.fn = cpts_pkg::FUNC_YIELD;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.fn;
        s_tdata  <= {1'b0, ev.count, ev.prio, ev.slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every awaited pick
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (picks_pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic send_alone(sched_event_t ev);
        send_event(ev);
        wait_for_results();
    endtask

    task automatic write_idle_prio(logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int n;
        int phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle only with zero priority, refill leaves nothing to run
        write_idle_prio(8'd0);
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_YIELD, 0, 0, 0));
        // refused create of the idle slot, then the extremes
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 0, 255, 511));
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, cpts_pkg::TASK_SLOTS - 1, 255, 511));
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 1, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_YIELD, 0, 0, 0));
        // exit leaves only spent zero-priority tasks: refill, then stuck
        send_alone(mk_event(cpts_pkg::FUNC_EXIT, 0, 0, 0));
        // overwrite the zombie and run its last tick
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, cpts_pkg::TASK_SLOTS - 1, 1, 1));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        write_idle_prio(8'd255);
        // equal counters: the lower index wins
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 2, 200, 300));
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 3, 100, 300));
        send_alone(mk_event(cpts_pkg::FUNC_YIELD, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_EXIT, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_EXIT, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 42, 85, 170));
        send_alone(mk_event(cpts_pkg::FUNC_CREATE, 21, 170, 341));
        send_alone(mk_event(cpts_pkg::FUNC_YIELD, 0, 0, 0));
        send_alone(mk_event(cpts_pkg::FUNC_TICK, 0, 0, 0));

        // Random phases with different idle patterns on both streams
        for (phase = 0; phase < 3; phase++)
        begin
            wait_for_results();
            case (phase)
                0:
                begin
                    write_idle_prio(8'd1);
                    tx_idle_pct = 23;
                    rx_idle_pct <= 67;
                end
                1:
                begin
                    write_idle_prio(8'($urandom_range(0, 255)));
                    tx_idle_pct = 67;
                    rx_idle_pct <= 23;
                end
                default:
                begin
                    write_idle_prio(8'($urandom_range(0, 2)));
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    // exit tasks until the idle task runs, then exit it too
                    for (n = 0; n < 2 * cpts_pkg::TASK_SLOTS && pred_current != '0; n++)
                        send_alone(mk_event(cpts_pkg::FUNC_EXIT, 0, 0, 0));
                    guard_idle = 1'b0;
                    send_alone(mk_event(cpts_pkg::FUNC_EXIT, 0, 0, 0));
                end
            endcase

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 120)
                    stall_req <= 1'b1;
                send_event(random_event());
            end
        end

        // Drain and give the verdict
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && picks_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
